// File: sv/lqe_pkg.sv
// Shared types, constants and helper functions of the line to quad expander.
package lqe_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int COUNT_W          = 13;
    localparam int SLOT_W           = 12;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int S_TDATA_W        = 224;
    localparam int M_TDATA_W        = 144;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_Z   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESENT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THICK   = 3'd4;

    // Input op codes
    localparam logic OP_BEGIN_FRAME = 1'b0;
    localparam logic OP_ADD_LINE    = 1'b1;

    localparam logic [15:0] FWD_Z_RESET = 16'sd16384;
    localparam logic [15:0] THICK_RESET = 16'd655;
    localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_MAG,
        ST_NORM,
        ST_SQR,
        ST_SQRT,
        ST_MT,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Corner emitted for vertex k: bit 0 selects end, bit 1 subtracts the side
    function automatic logic [1:0] corner_of(input logic [2:0] k);
        logic [1:0] c;
        unique case (k)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd2;
            3'd4:    c = 2'd1;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/line_to_quad_expander.sv
// Top level of the line to quad expander: sequencer, shared multiplier, root and divider.
//
// Each add-line beat is expanded into six vertex beats (two triangles of a camera-facing
// quad); begin-frame beats and dropped lines give no output. A line runs through these steps
// in order: the cross product on the shared 34x31 multiplier, the magnitudes, the
// normalizing shift, one step per bit of shift, the squares, the bit-serial square root,
// then for each of the three side components a multiply and a bit-serial division, the six
// vertex beats, and the idle state that takes the next beat. A vertex that the output holds
// and that is not taken stalls the vertex beats. A line whose cross product is zero skips
// straight to the vertex beats. The input is ready only while the sequencer is idle; a
// finished vertex may still wait on the output while the next line is taken.
module line_to_quad_expander #(
    parameter int MAX_VERTICES = lqe_pkg::MAX_VERTICES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lqe_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lqe_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, rgba
    input  logic [lqe_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, vertex_rgba, 4 zero bits
    output logic [lqe_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast
);

    lqe_pkg::t_state r_state, n_state;

    logic signed [15:0] r_fwd_x, r_fwd_y, r_fwd_z;
    logic               r_present;
    logic [15:0]        r_thick;
    logic [lqe_pkg::COUNT_W-1:0] r_count;

    logic signed [31:0] r_st [3];
    logic signed [31:0] r_en [3];
    logic signed [32:0] r_d  [3];
    logic [31:0]        r_rgba;
    logic signed [49:0] r_c  [3];
    logic [48:0]        r_m  [3];
    logic [16:0]        r_side [3];
    logic [63:0]        r_x, r_res, r_bit;
    logic [31:0]        r_rem;
    logic [16:0]        r_nlo;
    logic [15:0]        r_q;
    logic [5:0]         r_cnt;
    logic [1:0]         r_j;
    logic [2:0]         r_k;
    logic signed [64:0] r_prod;

    logic               r_mvalid;
    logic [lqe_pkg::SLOT_W-1:0] r_slot;
    logic [31:0]        r_px, r_py, r_pz, r_orgba;
    logic               r_last;

    logic               w_accept, w_full, w_load;
    logic signed [33:0] w_ma;
    logic signed [30:0] w_mb;
    logic signed [64:0] w_mp;
    logic [2:0]         w_step;
    logic               w_big, w_small, w_czero;
    logic [63:0]        w_trial_sq;
    logic [46:0]        w_num;
    logic [32:0]        w_trial, w_dv;
    logic               w_ge;
    logic [1:0]         w_corner;
    logic [31:0]        w_pos [3];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_full   = ({1'b0, r_count} + 14'd6) >= 14'(MAX_VERTICES);
    assign w_step   = r_cnt[3:1];

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            lqe_pkg::ST_CROSS: begin
                unique case (w_step)
                    3'd0: begin w_ma = 34'(r_d[2]); w_mb = 31'(r_fwd_y); end
                    3'd1: begin w_ma = 34'(r_d[1]); w_mb = 31'(r_fwd_z); end
                    3'd2: begin w_ma = 34'(r_d[0]); w_mb = 31'(r_fwd_z); end
                    3'd3: begin w_ma = 34'(r_d[2]); w_mb = 31'(r_fwd_x); end
                    3'd4: begin w_ma = 34'(r_d[1]); w_mb = 31'(r_fwd_x); end
                    3'd5: begin w_ma = 34'(r_d[0]); w_mb = 31'(r_fwd_y); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            lqe_pkg::ST_SQR: begin
                w_ma = $signed({4'b0, r_m[r_cnt[2:1]][29:0]});
                w_mb = $signed({1'b0, r_m[r_cnt[2:1]][29:0]});
            end
            lqe_pkg::ST_MT: begin
                w_ma = $signed({4'b0, r_m[r_j][29:0]});
                w_mb = $signed({15'b0, r_thick});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    assign w_big   = |{r_m[0][48:30], r_m[1][48:30], r_m[2][48:30]};
    assign w_small = ~|{r_m[0][48:29], r_m[1][48:29], r_m[2][48:29]};
    assign w_czero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    assign w_trial_sq = r_res + r_bit;
    assign w_num   = r_prod[46:0] + {16'b0, r_res[30:0]};
    assign w_trial = {r_rem, r_nlo[16]};
    assign w_dv    = {r_res[31:0], 1'b0};
    assign w_ge    = w_trial >= w_dv;

    // Vertex position of corner r_k, saturated
    assign w_corner = lqe_pkg::corner_of(r_k);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [33:0] base, sd;
            base = w_corner[0] ? 34'(r_en[i]) : 34'(r_st[i]);
            sd   = $signed({17'b0, r_side[i]});
            if (r_c[i][49] ^ w_corner[1]) begin
                w_pos[i] = lqe_pkg::sat32(base - sd);
            end else begin
                w_pos[i] = lqe_pkg::sat32(base + sd);
            end
        end
    end

    assign w_load = (r_state == lqe_pkg::ST_EMIT) && (!r_mvalid || m_axis_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lqe_pkg::ST_IDLE: begin
                if (w_accept && s_axis_tuser[0] == lqe_pkg::OP_ADD_LINE && !w_full && r_present) begin
                    n_state = lqe_pkg::ST_CROSS;
                end
            end
            lqe_pkg::ST_CROSS: if (r_cnt == 6'd11) n_state = lqe_pkg::ST_MAG;
            lqe_pkg::ST_MAG:   n_state = w_czero ? lqe_pkg::ST_EMIT : lqe_pkg::ST_NORM;
            lqe_pkg::ST_NORM:  if (!w_big && !w_small) n_state = lqe_pkg::ST_SQR;
            lqe_pkg::ST_SQR:   if (r_cnt == 6'd5) n_state = lqe_pkg::ST_SQRT;
            lqe_pkg::ST_SQRT:  if (r_cnt == 6'd31) n_state = lqe_pkg::ST_MT;
            lqe_pkg::ST_MT:    if (r_cnt == 6'd1) n_state = lqe_pkg::ST_DIV;
            lqe_pkg::ST_DIV: begin
                if (r_cnt == 6'd16) begin
                    n_state = (r_j == 2'd2) ? lqe_pkg::ST_EMIT : lqe_pkg::ST_MT;
                end
            end
            lqe_pkg::ST_EMIT:  if (w_load && r_k == 3'd5) n_state = lqe_pkg::ST_IDLE;
            default:           n_state = lqe_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == lqe_pkg::ST_IDLE);
        m_axis_tvalid = r_mvalid;
        m_axis_tlast  = r_last;
        m_axis_tdata  = {4'b0, r_orgba, r_pz, r_py, r_px, r_slot};
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lqe_pkg::ST_IDLE;
            r_fwd_x   <= '0;
            r_fwd_y   <= '0;
            r_fwd_z   <= lqe_pkg::FWD_Z_RESET;
            r_present <= 1'b0;
            r_thick   <= lqe_pkg::THICK_RESET;
            r_count   <= '0;
            r_mvalid  <= 1'b0;
            r_cnt     <= '0;
            r_j       <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    lqe_pkg::CFG_FWD_X:   r_fwd_x   <= i_cfg_wdata;
                    lqe_pkg::CFG_FWD_Y:   r_fwd_y   <= i_cfg_wdata;
                    lqe_pkg::CFG_FWD_Z:   r_fwd_z   <= i_cfg_wdata;
                    lqe_pkg::CFG_PRESENT: r_present <= i_cfg_wdata[0];
                    lqe_pkg::CFG_THICK:   r_thick   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_accept && s_axis_tuser[0] == lqe_pkg::OP_BEGIN_FRAME) begin
                r_count <= '0;
            end
            if (w_load) begin
                r_mvalid <= 1'b1;
                r_count  <= r_count + 1'b1;
                r_k      <= (r_k == 3'd5) ? 3'd0 : r_k + 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            // Step counter restarts on every state change
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == lqe_pkg::ST_IDLE) begin
                r_j <= '0;
                r_k <= '0;
            end else if (r_state == lqe_pkg::ST_DIV && r_cnt == 6'd16) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_mp;
        if (w_load) begin
            r_slot   <= r_count[lqe_pkg::SLOT_W-1:0];
            r_px     <= w_pos[0];
            r_py     <= w_pos[1];
            r_pz     <= w_pos[2];
            r_orgba  <= r_rgba;
            r_last   <= (r_k == 3'd5);
        end
        unique case (r_state)
            lqe_pkg::ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_st[i] <= s_axis_tdata[32*i +: 32];
                    r_en[i] <= s_axis_tdata[32*(i+3) +: 32];
                    r_d[i]  <= 33'($signed(s_axis_tdata[32*(i+3) +: 32]))
                             - 33'($signed(s_axis_tdata[32*i +: 32]));
                    r_c[i]  <= '0;
                end
                r_rgba <= s_axis_tdata[223:192];
            end
            lqe_pkg::ST_CROSS: begin
                if (r_cnt[0]) begin
                    if (r_cnt[1]) begin
                        r_c[r_cnt[3:2]] <= r_c[r_cnt[3:2]] - r_prod[49:0];
                    end else begin
                        r_c[r_cnt[3:2]] <= r_c[r_cnt[3:2]] + r_prod[49:0];
                    end
                end
            end
            lqe_pkg::ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]    <= r_c[i][49] ? 49'(-r_c[i]) : r_c[i][48:0];
                    r_side[i] <= '0;
                end
                r_x <= '0;
            end
            lqe_pkg::ST_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_big) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (w_small) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            lqe_pkg::ST_SQR: begin
                if (r_cnt[0]) begin
                    r_x <= r_x + r_prod[63:0];
                end
                r_res <= '0;
                r_bit <= lqe_pkg::SQRT_BIT0;
            end
            lqe_pkg::ST_SQRT: begin
                if (r_x >= w_trial_sq) begin
                    r_x   <= r_x - w_trial_sq;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            lqe_pkg::ST_MT: begin
                // Quotient fits in 17 bits, so the top of the numerator seeds the remainder
                if (r_cnt[0]) begin
                    r_rem <= {2'b0, w_num[46:17]};
                    r_nlo <= w_num[16:0];
                    r_q   <= '0;
                end
            end
            lqe_pkg::ST_DIV: begin
                if (w_ge) begin
                    r_rem <= 32'(w_trial - w_dv);
                end else begin
                    r_rem <= w_trial[31:0];
                end
                r_nlo <= {r_nlo[15:0], 1'b0};
                r_q   <= {r_q[14:0], w_ge};
                if (r_cnt == 6'd16) begin
                    r_side[r_j] <= {r_q, w_ge};
                end
            end
            lqe_pkg::ST_EMIT: ;
            default: ;
        endcase
    end

endmodule

// File: dv/testbench.sv
// Testbench of the line to quad expander: stream stimulus, vertex prediction and checking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lqe_pkg::SLOT_W-1:0] slot;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        logic [31:0]       rgba;
        logic              last;
    } t_vertex;

    class quad_scoreboard;
        logic [15:0]        fwd_x = 16'd0;
        logic [15:0]        fwd_y = 16'd0;
        logic [15:0]        fwd_z = lqe_pkg::FWD_Z_RESET;
        logic               present = 1'b0;
        logic [15:0]        thick = lqe_pkg::THICK_RESET;
        logic [lqe_pkg::COUNT_W-1:0] count = '0;
        t_vertex            vertex_q[$];
        int                 errors = 0;

        function void write_reg(logic [lqe_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] val);
            case (addr)
                lqe_pkg::CFG_FWD_X:   fwd_x = val;
                lqe_pkg::CFG_FWD_Y:   fwd_y = val;
                lqe_pkg::CFG_FWD_Z:   fwd_z = val;
                lqe_pkg::CFG_PRESENT: present = val[0];
                lqe_pkg::CFG_THICK:   thick = val;
                default: ;
            endcase
        endfunction

        static function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        static function logic [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        // Expand an accepted add-line beat into the six vertices it must produce (none if dropped)
        function void note_line(logic op, logic [lqe_pkg::S_TDATA_W-1:0] d);
            longint st[3], en[3], c[3], side[3], fx, fy, fz, dx, dy, dz, pos[3];
            longint unsigned m[3], mx, sum, len, q;
            int corner_sel[6] = '{0, 1, 2, 2, 1, 3};
            t_vertex v;
            if (op == lqe_pkg::OP_BEGIN_FRAME) begin
                count = '0;
                return;
            end
            if (int'(count) + 6 >= lqe_pkg::MAX_VERTICES_DEF || !present) return;
            for (int i = 0; i < 3; i++) begin
                st[i] = longint'($signed(d[32*i +: 32]));
                en[i] = longint'($signed(d[96 + 32*i +: 32]));
            end
            dx = en[0] - st[0];
            dy = en[1] - st[1];
            dz = en[2] - st[2];
            fx = longint'($signed(fwd_x));
            fy = longint'($signed(fwd_y));
            fz = longint'($signed(fwd_z));
            c[0] = fy * dz - fz * dy;
            c[1] = fz * dx - fx * dz;
            c[2] = fx * dy - fy * dx;
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = c[i] < 0 ? -c[i] : c[i];
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0) begin
                side = '{0, 0, 0};
            end else begin
                while (mx >= (64'd1 << 30)) begin
                    mx >>= 1;
                    for (int i = 0; i < 3; i++) m[i] >>= 1;
                end
                while (mx < (64'd1 << 29)) begin
                    mx <<= 1;
                    for (int i = 0; i < 3; i++) m[i] <<= 1;
                end
                sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                len = floor_sqrt(sum);
                for (int i = 0; i < 3; i++) begin
                    q = (m[i] * thick + len) / (2 * len);
                    side[i] = c[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
            for (int k = 0; k < 6; k++) begin
                // bit 0 picks the end point, bit 1 subtracts the side vector
                for (int i = 0; i < 3; i++) begin
                    pos[i] = corner_sel[k][0] ? en[i] : st[i];
                    pos[i] = corner_sel[k][1] ? pos[i] - side[i] : pos[i] + side[i];
                end
                v.slot = lqe_pkg::SLOT_W'(count + k);
                v.px = clamp32(pos[0]);
                v.py = clamp32(pos[1]);
                v.pz = clamp32(pos[2]);
                v.rgba = d[223:192];
                v.last = (k == 5);
                vertex_q.push_back(v);
            end
            count = count + 6;
        endfunction

        function void check_vertex(logic [lqe_pkg::M_TDATA_W-1:0] td, logic tl);
            t_vertex e;
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex beat: tdata=%h", td);
                errors++;
                return;
            end
            e = vertex_q.pop_front();
            if (td[11:0] !== e.slot) begin
                $error("vertex_slot: expected %0d, actual %0d", e.slot, td[11:0]);
                errors++;
            end
            if (td[43:12] !== e.px) begin
                $error("pos_x: expected %h, actual %h", e.px, td[43:12]);
                errors++;
            end
            if (td[75:44] !== e.py) begin
                $error("pos_y: expected %h, actual %h", e.py, td[75:44]);
                errors++;
            end
            if (td[107:76] !== e.pz) begin
                $error("pos_z: expected %h, actual %h", e.pz, td[107:76]);
                errors++;
            end
            if (td[139:108] !== e.rgba) begin
                $error("vertex_rgba: expected %h, actual %h", e.rgba, td[139:108]);
                errors++;
            end
            if (tl !== e.last) begin
                $error("last: expected %b, actual %b", e.last, tl);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [lqe_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [lqe_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [lqe_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [lqe_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    quad_scoreboard sb = new();
    int  burst_left = 0;
    int  rx_left = 0;
    bit  rx_stall = 0;
    bit  rx_free = 0;

    line_to_quad_expander i_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: alternate ready runs and stalls of random length, unless rx_free holds ready high
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_stall = !rx_stall;
            rx_left = rx_stall ? $urandom_range(1, 8) : $urandom_range(1, 30);
        end
        rx_left--;
        m_axis_tready <= rx_free || !rx_stall;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_line(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_vertex(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_beat(logic op, logic [lqe_pkg::S_TDATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic drain_vertices();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.vertex_q.size() != 0) @(posedge i_clk);
    endtask

    // Let a dropped line finish before touching the registers
    task automatic settle();
        drain_vertices();
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lqe_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(addr, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [lqe_pkg::S_TDATA_W-1:0] pack_line(logic [31:0] sx,
            logic [31:0] sy, logic [31:0] sz, logic [31:0] ex, logic [31:0] ey,
            logic [31:0] ez, logic [31:0] rgba);
        return {rgba, ez, ey, ex, sz, sy, sx};
    endfunction

    function automatic logic [lqe_pkg::S_TDATA_W-1:0] random_line();
        logic [31:0] s[3], e[3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0, 1: begin
                    s[i] = $urandom();
                    e[i] = $urandom();
                end
                2: begin
                    // near the edge of the range so the corners saturate
                    s[i] = $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
                                                : 32'h8000_0000 + $urandom_range(0, 65535);
                    e[i] = s[i] + $urandom_range(0, 255) - 128;
                end
                3: begin
                    s[i] = $urandom();
                    e[i] = s[i];
                end
                4: begin
                    s[i] = $urandom();
                    e[i] = (i == 2) ? $urandom() : s[i];
                end
                default: begin
                    s[i] = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
                    e[i] = s[i] + 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh2_0000);
                end
            endcase
        end
        return pack_line(s[0], s[1], s[2], e[0], e[1], e[2], $urandom());
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 14) == 0) send_beat(lqe_pkg::OP_BEGIN_FRAME, $urandom());
            else send_beat(lqe_pkg::OP_ADD_LINE, random_line());
            if (i == n / 2) drain_vertices();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no camera yet: the line is dropped
        send_beat(lqe_pkg::OP_ADD_LINE, random_line());
        send_beat(lqe_pkg::OP_BEGIN_FRAME, '0);
        settle();
        write_reg(lqe_pkg::CFG_PRESENT, 16'hFFFF);
        write_reg(5, 16'h1234);
        write_reg(7, 16'hFFFF);
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // parallel to the default forward vector
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(1, 2, 3, 1, 2, 32'h7FFF_FFFF, 32'h0));
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(0, 0, 0, 32'h0001_0000, 0, 0,
                32'h1234_5678));
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hA5A5_A5A5));
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(32'h8000_0000, 32'h7FFF_FFF0, 0,
                32'h8000_0000, 32'h8000_0010, 32'h0000_0010, 32'h5A5A_5A5A));
        settle();
        write_reg(lqe_pkg::CFG_THICK, 16'hFFFF);
        write_reg(lqe_pkg::CFG_FWD_X, 16'h8000);
        write_reg(lqe_pkg::CFG_FWD_Y, 16'h7FFF);
        write_reg(lqe_pkg::CFG_FWD_Z, 16'h8000);
        write_reg(lqe_pkg::CFG_PRESENT, 16'h0001);
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(0, 0, 0, 32'h0000_0100, 32'h0000_0300,
                1, 0));
        send_beat(lqe_pkg::OP_ADD_LINE, random_line());
        settle();
        write_reg(lqe_pkg::CFG_THICK, 16'h0000);
        send_beat(lqe_pkg::OP_ADD_LINE, pack_line(0, 0, 0, 32'h0100_0000, 32'h0200_0000,
                0, 1));
        send_beat(lqe_pkg::OP_ADD_LINE, random_line());
        send_beat(lqe_pkg::OP_BEGIN_FRAME, '1);
        settle();

        write_reg(lqe_pkg::CFG_THICK, 16'd655);
        write_reg(lqe_pkg::CFG_FWD_X, 16'h0000);
        write_reg(lqe_pkg::CFG_FWD_Y, 16'h0000);
        write_reg(lqe_pkg::CFG_FWD_Z, 16'h4000);
        random_phase(80);
        for (int p = 0; p < 3; p++) begin
            settle();
            write_reg(lqe_pkg::CFG_FWD_X, $urandom());
            write_reg(lqe_pkg::CFG_FWD_Y, $urandom());
            write_reg(lqe_pkg::CFG_FWD_Z, $urandom());
            write_reg(lqe_pkg::CFG_THICK, p == 0 ? 16'hFFFF : 16'($urandom()));
            rx_free = (p == 1);
            random_phase(75);
        end
        rx_free = 0;

        settle();
        send_beat(lqe_pkg::OP_BEGIN_FRAME, '0);
        send_beat(lqe_pkg::OP_ADD_LINE, random_line());

        settle();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
